[src/input_run_length_recorder_player_top_defines.svh]
// Assertion macros for the run-length recorder and player.
`ifndef INPUT_RUN_LENGTH_RECORDER_PLAYER_TOP_DEFINES_SVH
`define INPUT_RUN_LENGTH_RECORDER_PLAYER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IRLRP_ASSERT_IMPLY(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("irlrp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IRLRP_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("irlrp next-cycle check failed");

`endif

[src/irlrp_pkg.sv]
// Shared constants and types of the run-length recorder and player.
package irlrp_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int ADDR_W     = $clog2(SLOT_COUNT);
    localparam int KEY_W      = 10;
    localparam int DUR_W      = 16;
    localparam int IDX_W      = 8;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_PLAY   = 2'd2;

    localparam logic [KEY_W-1:0] START_BIT = KEY_W'(10'h008);
    localparam logic [DUR_W-1:0] DUR_MAX   = '1;
    localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(SLOT_COUNT - 2);

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_keys;
        logic [DUR_W-1:0]  wr_dur;
        logic              clear;
    } store_req_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] button;
        logic [KEY_W-1:0] presses;
        logic             ended;
    } result_t;

endpackage

[src/irlrp_store.sv]
// Slot store: keys and duration per slot, registered read, valid bits for clear.
module irlrp_store
    import irlrp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  store_req_t       req,
    output logic [KEY_W-1:0] rd_keys,
    output logic [DUR_W-1:0] rd_dur
);

    logic [KEY_W+DUR_W-1:0] mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  valid_reg;
    logic [KEY_W+DUR_W-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= {req.wr_keys, req.wr_dur};
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // a slot never written since reset or the last clear reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (req.rd_en) begin
            rd_valid_reg <= valid_reg[req.rd_addr] && !req.clear;
        end
    end

    assign rd_keys = rd_valid_reg ? rd_data_reg[KEY_W+DUR_W-1:DUR_W] : '0;
    assign rd_dur  = rd_valid_reg ? rd_data_reg[DUR_W-1:0] : '0;

endmodule

[src/irlrp_ctrl.sv]
// Sequencer: per-word read, modify and write back of the slot store.
module irlrp_ctrl
    import irlrp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [1:0]       cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_op,
    input  logic [KEY_W-1:0] in_keys,
    input  logic [IDX_W-1:0] in_idx,
    input  logic [KEY_W-1:0] in_ekeys,
    input  logic [DUR_W-1:0] in_edur,
    output store_req_t       req,
    input  logic [KEY_W-1:0] rd_keys,
    input  logic [DUR_W-1:0] rd_dur,
    output result_t          res,
    input  logic             out_free
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_EXEC2 = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [DUR_W-1:0]  frames_reg, frames_next;
    logic [KEY_W-1:0]  prev_reg, prev_next;

    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  keys_reg, ekeys_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DUR_W-1:0]  edur_reg;

    logic [KEY_W-1:0]  bout_reg, bout_next;
    logic [KEY_W-1:0]  press_reg, press_next;
    logic              ended_reg, ended_next;

    logic [ADDR_W-1:0] ptr_plus;
    logic              accept;
    logic              idx_ok;
    logic              ptr_at_end;
    logic [DUR_W-1:0]  frames_cur;

    assign ptr_plus   = ptr_reg + ADDR_W'(1);
    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign idx_ok     = 32'(idx_reg) < SLOT_COUNT;
    assign ptr_at_end = ptr_reg >= PTR_LAST;
    assign frames_cur = (frames_reg == '0) ? rd_dur : frames_reg;

    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        frames_next = frames_reg;
        prev_next   = prev_reg;
        bout_next   = bout_reg;
        press_next  = press_reg;
        ended_next  = ended_reg;
        req         = '0;

        unique case (state_reg)
            S_IDLE: begin
                // read address depends only on held state and the operation
                req.rd_en = accept;
                if (in_op == OP_RESTART) begin
                    req.rd_addr = '0;
                end else if (mode_reg == MODE_PLAY && frames_reg == '0) begin
                    req.rd_addr = ptr_plus;
                end else begin
                    req.rd_addr = ptr_reg;
                end
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                bout_next  = keys_reg;
                press_next = '0;
                ended_next = 1'b0;
                state_next = S_OUT;
                case (op_reg)
                    OP_LOAD: begin
                        req.wr_en   = idx_ok;
                        req.wr_addr = ADDR_W'(idx_reg);
                        req.wr_keys = ekeys_reg;
                        req.wr_dur  = edur_reg;
                    end
                    OP_RESTART: begin
                        if (mode_reg == MODE_RECORD) begin
                            req.clear   = 1'b1;
                            frames_next = '0;
                        end else begin
                            frames_next = rd_dur;
                        end
                        ptr_next  = '0;
                        prev_next = '0;
                    end
                    OP_TICK: begin
                        if (mode_reg == MODE_RECORD) begin
                            if (ptr_at_end) begin
                                press_next = START_BIT;
                                ended_next = 1'b1;
                            end else if (keys_reg == rd_keys) begin
                                if (rd_dur == DUR_MAX) begin
                                    // run full: next slot keeps counting on its old duration
                                    req.rd_en   = 1'b1;
                                    req.rd_addr = ptr_plus;
                                    state_next  = S_EXEC2;
                                end else begin
                                    req.wr_en   = 1'b1;
                                    req.wr_addr = ptr_reg;
                                    req.wr_keys = keys_reg;
                                    req.wr_dur  = rd_dur + DUR_W'(1);
                                end
                            end else begin
                                ptr_next    = ptr_plus;
                                req.wr_en   = 1'b1;
                                req.wr_addr = ptr_plus;
                                req.wr_keys = keys_reg;
                                req.wr_dur  = DUR_W'(1);
                            end
                        end else if (mode_reg == MODE_PLAY) begin
                            if (ptr_at_end || frames_reg == DUR_MAX || keys_reg != '0) begin
                                bout_next  = '0;
                                press_next = START_BIT;
                                ended_next = 1'b1;
                            end else begin
                                if (frames_reg == '0) begin
                                    ptr_next = ptr_plus;
                                end
                                frames_next = frames_cur - DUR_W'(1);
                                bout_next   = rd_keys;
                                press_next  = (prev_reg ^ rd_keys) & rd_keys;
                                prev_next   = rd_keys;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EXEC2: begin
                req.wr_en   = 1'b1;
                req.wr_addr = ptr_plus;
                req.wr_keys = keys_reg;
                req.wr_dur  = rd_dur + DUR_W'(1);
                ptr_next    = ptr_plus;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.valid   = (state_reg == S_OUT);
    assign res.button  = bout_reg;
    assign res.presses = press_reg;
    assign res.ended   = ended_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_OFF;
            ptr_reg    <= '0;
            frames_reg <= '0;
            prev_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            frames_reg <= frames_next;
            prev_reg   <= prev_next;
            if (cfg_wen) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bout_reg  <= bout_next;
        press_reg <= press_next;
        ended_reg <= ended_next;
        if (accept) begin
            op_reg    <= in_op;
            keys_reg  <= in_keys;
            idx_reg   <= in_idx;
            ekeys_reg <= in_ekeys;
            edur_reg  <= in_edur;
        end
    end

endmodule

[src/input_run_length_recorder_player_top.sv]
// Top level of the run-length key recorder and player with its output register.
// Each accepted word runs through the sequencer states in order: S_IDLE
// issues the slot read, S_EXEC evaluates and writes back, S_OUT hands the
// result to the output register; the next word is accepted only after that.
// A record tick that overflows a full run (duration 65535 with unchanged keys)
// needs a second read of the next slot in S_EXEC2. The slot store has a single
// read port and a registered read. A new word is accepted while the previous
// result still waits in the output register; the sequencer only holds in its
// last step if that register is still full. Reset and a record-mode restart
// clear the whole store at once through per-slot valid bits, so no clearing
// pass is needed. The mode register is written through cfg_wen and cfg_wdata
// and must only change while no word is in flight.
module input_run_length_recorder_player_top
    import irlrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // mode register: 0 off, 1 record, 2 playback, 3 acts as off
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // keys[9:0], entry_index[17:10], entry_keys[27:18], entry_duration[43:28], zero pad
    input  logic [47:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // button_out[9:0], new_presses[19:10], zero pad
    output logic [23:0] m_tdata,
    // ended: recording or playback forced to end
    output logic        m_tlast
);

    `include "input_run_length_recorder_player_top_defines.svh"

    store_req_t       req;
    result_t          res;
    logic [KEY_W-1:0] rd_keys;
    logic [DUR_W-1:0] rd_dur;

    logic             m_tvalid_reg;
    logic [KEY_W-1:0] m_button_reg;
    logic [KEY_W-1:0] m_press_reg;
    logic             m_last_reg;
    logic             out_free;
    logic             push;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign push     = res.valid && out_free;

    irlrp_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_keys (rd_keys),
        .rd_dur  (rd_dur)
    );

    irlrp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_keys   (s_tdata[9:0]),
        .in_idx    (s_tdata[17:10]),
        .in_ekeys  (s_tdata[27:18]),
        .in_edur   (s_tdata[43:28]),
        .req       (req),
        .rd_keys   (rd_keys),
        .rd_dur    (rd_dur),
        .res       (res),
        .out_free  (out_free)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_button_reg <= res.button;
            m_press_reg  <= res.presses;
            m_last_reg   <= res.ended;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_press_reg, m_button_reg};
    assign m_tlast  = m_last_reg;

    // a forced end always reports the start bit alone
    `IRLRP_ASSERT_IMPLY(a_end_start_bit, m_tvalid && m_tlast, m_tdata[19:10] == START_BIT)
    // one word at a time through the sequencer
    `IRLRP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a waiting result is never overwritten
    `IRLRP_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready && !push, m_tvalid)

endmodule
